// ===== rtl/core/lpe_pkg.sv =====
// Shared types and fixed-point constants for the Legendre polynomial evaluator.
// No dependencies; imported by rtl/core/legendre_poly_eval.sv.
`default_nettype none

package lpe_pkg;

  // Sequencer states: one recurrence step runs from ST_MUL_XL through ST_FIN.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_XL,
    ST_ROUND,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUB,
    ST_MUL_D,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  // Operand pairs fed to the shared multiplier.
  typedef enum logic [1:0] {
    MS_X_L1,
    MS_P_ODD,
    MS_L2_KM1,
    MS_L1_ODD
  } mul_sel_t;

  localparam int DEG_W      = 6;
  localparam int VAL_W      = 32;
  localparam int SLOPE_W    = 43;
  localparam int K_W        = 7;   // step index, holds up to degree + 1
  localparam int PROD_W     = 64;
  localparam int NUM_W      = 39;  // recurrence numerator before division
  localparam int DVD_W      = 40;  // divider dividend, multiple of DIV_BITS
  localparam int DIV_BITS   = 4;   // quotient bits per divider cycle
  localparam int DIV_STEPS  = DVD_W / DIV_BITS;
  localparam int DIV_CNT_W  = 4;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 112;
  localparam int FRAC_W     = 30;

  localparam logic signed [VAL_W-1:0]   ONE_Q30   = 32'sh4000_0000;
  localparam logic signed [VAL_W-1:0]   NEG_ONE   = -32'sh4000_0000;
  localparam logic signed [SLOPE_W:0]   SLOPE_MAX = 44'sd2199023255552;
  localparam logic signed [SLOPE_W:0]   SLOPE_MIN = -44'sd2199023255552;
  localparam logic signed [VAL_W:0]     Q_MAX     = 33'sd2147483647;
  localparam logic signed [VAL_W:0]     Q_MIN     = -33'sd2147483648;
  localparam logic signed [PROD_W-1:0]  HALF_LSB  = 64'sd536870912;

endpackage

`default_nettype wire

// ===== rtl/core/legendre_poly_eval.sv =====
// Legendre polynomial evaluator: L_n(x), L'_n(x) and L_{n+1}(x) - L_{n-1}(x).
// Depends on rtl/core/lpe_pkg.sv.
// A step multiplies x by L_{k-1} on the shared 32x32 multiplier, rounds, forms two more products,
// subtracts, forms a fourth product, runs the 4-bit-per-cycle divider and updates; the result is then loaded.
// One item at a time: a new beat is accepted once the previous item has moved to the result registers.
// Reset (rst, synchronous, active high) returns the sequencer to idle and empties the output.
`default_nettype none

module legendre_poly_eval #(
  parameter int MAX_DEGREE = 63
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input stream. tdata from bit 0: degree[5:0], point[31:0], zero pad.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [39:0]  s_tdata,
  // Result stream. tdata from bit 0: value[31:0], slope[42:0], q_value[31:0], zero pad.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [111:0]      m_tdata
);

  import lpe_pkg::*;

  // Effective degree cap: the degree field cannot exceed 63 anyway.
  localparam int          DEG_CAP   = (MAX_DEGREE < 63) ? MAX_DEGREE : 63;
  localparam logic [DEG_W-1:0] DEG_CAP_L = DEG_W'(DEG_CAP);

  state_t state, state_next;
  mul_sel_t mul_sel;

  // Item operands and recurrence state.
  logic signed [VAL_W-1:0]   x;
  logic [DEG_W-1:0]          n;
  logic [K_W-1:0]            k;
  logic signed [VAL_W-1:0]   lm1, lm2;
  logic signed [SLOPE_W-1:0] dm1, dm2;

  // Step intermediates.
  logic signed [PROD_W-1:0]  prod;
  logic signed [VAL_W-1:0]   p;
  logic signed [NUM_W-1:0]   acc;
  logic signed [NUM_W-1:0]   num;
  logic                      neg;

  // Divider: dvd shifts the dividend out and the quotient in.
  logic [DVD_W-1:0]          dvd;
  logic [K_W-1:0]            rem;
  logic [DIV_CNT_W-1:0]      dcnt;

  // Result registers; they hold the beat on offer so the next item can start.
  logic signed [VAL_W-1:0]   res_value;
  logic signed [SLOPE_W-1:0] res_slope;
  logic signed [VAL_W-1:0]   res_q;
  logic                      out_valid;

  // Combinational helpers.
  logic [DEG_W-1:0]          deg_in;
  logic signed [VAL_W-1:0]   pt_in, x_in;
  logic [K_W-1:0]            km1, odd;
  logic signed [VAL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_y;
  logic signed [PROD_W-1:0]  rnd_sum;
  logic [DVD_W-1:0]          dvd_load;
  logic [DVD_W-1:0]          dvd_step;
  logic [K_W-1:0]            rem_step;
  logic [VAL_W-1:0]          lk_mag;
  logic signed [VAL_W-1:0]   lk;
  logic signed [SLOPE_W:0]   dk_sum;
  logic signed [SLOPE_W-1:0] dk;
  logic signed [VAL_W:0]     q_diff;
  logic signed [VAL_W-1:0]   q_sat;
  logic                      last_step;
  logic                      div_done;
  logic                      in_beat;
  logic                      out_load;

  assign in_beat  = s_tvalid && s_tready;
  assign deg_in   = (s_tdata[DEG_W-1:0] > DEG_CAP_L) ? DEG_CAP_L : s_tdata[DEG_W-1:0];
  assign pt_in    = $signed(s_tdata[DEG_W +: VAL_W]);
  assign x_in     = (pt_in > ONE_Q30) ? ONE_Q30 : ((pt_in < NEG_ONE) ? NEG_ONE : pt_in);

  // k-1 is at most 63, so 2k-1 is k-1 shifted left with a one in the LSB.
  assign km1      = k - K_W'(1);
  assign odd      = {km1[K_W-2:0], 1'b1};
  assign last_step = (k == ({1'b0, n} + K_W'(1)));
  assign div_done  = (dcnt == DIV_CNT_W'(DIV_STEPS - 1));

  // A finished item moves into the result registers once they are free or
  // their beat is taken in the same cycle.
  assign out_load = (state == ST_OUT) && (!out_valid || m_tready);
  assign m_tvalid = out_valid;

  // Shared multiplier.
  always_comb begin
    case (mul_sel)
      MS_X_L1: begin
        mul_a = x;
        mul_b = lm1;
      end
      MS_P_ODD: begin
        mul_a = p;
        mul_b = $signed({{(VAL_W-K_W){1'b0}}, odd});
      end
      MS_L2_KM1: begin
        mul_a = lm2;
        mul_b = $signed({{(VAL_W-K_W){1'b0}}, km1});
      end
      MS_L1_ODD: begin
        mul_a = lm1;
        mul_b = $signed({{(VAL_W-K_W){1'b0}}, odd});
      end
      default: begin
        mul_a = x;
        mul_b = lm1;
      end
    endcase
  end

  assign mul_y = mul_a * mul_b;

  // Round x*L to Q1.30, ties away from zero: negative values add one less.
  assign rnd_sum = prod + HALF_LSB - (prod[PROD_W-1] ? 64'sd1 : 64'sd0);

  // Divider load: |num| + floor(k/2), both signs in one adder each.
  always_comb begin
    if (num[NUM_W-1]) begin
      dvd_load = DVD_W'(k >> 1) - DVD_W'(num);
    end else begin
      dvd_load = DVD_W'(num) + DVD_W'(k >> 1);
    end
  end

  // Four restoring division steps; the partial remainder stays below k.
  always_comb begin
    logic [K_W:0] trial;
    dvd_step = dvd;
    rem_step = rem;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_step, dvd_step[DVD_W-1]};
      if (trial >= {1'b0, k}) begin
        rem_step = K_W'(trial - {1'b0, k});
        dvd_step = {dvd_step[DVD_W-2:0], 1'b1};
      end else begin
        rem_step = trial[K_W-1:0];
        dvd_step = {dvd_step[DVD_W-2:0], 1'b0};
      end
    end
  end

  // New value: saturate the quotient magnitude, then restore the sign.
  assign lk_mag = (dvd > DVD_W'(ONE_Q30)) ? VAL_W'(ONE_Q30) : dvd[VAL_W-1:0];
  assign lk     = neg ? -$signed(lk_mag) : $signed(lk_mag);

  // Derivative step, prod holds (2k-1)*L_{k-1} at this point.
  assign dk_sum = $signed({dm2[SLOPE_W-1], dm2}) + $signed(prod[SLOPE_W:0]);
  assign dk = (dk_sum > SLOPE_MAX) ? SLOPE_W'(SLOPE_MAX) :
              ((dk_sum < SLOPE_MIN) ? SLOPE_W'(SLOPE_MIN) : dk_sum[SLOPE_W-1:0]);

  // Final difference L_{n+1} - L_{n-1}, saturated to the 32-bit range.
  assign q_diff = $signed({lk[VAL_W-1], lk}) - $signed({lm2[VAL_W-1], lm2});
  assign q_sat  = (q_diff > Q_MAX) ? VAL_W'(Q_MAX) :
                  ((q_diff < Q_MIN) ? VAL_W'(Q_MIN) : q_diff[VAL_W-1:0]);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          state_next = (deg_in == '0) ? ST_OUT : ST_MUL_XL;
        end
      end
      ST_MUL_XL: state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_MUL_A;
      ST_MUL_A:  state_next = ST_MUL_B;
      ST_MUL_B:  state_next = ST_SUB;
      ST_SUB:    state_next = ST_MUL_D;
      ST_MUL_D:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = last_step ? ST_OUT : ST_MUL_XL;
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: input handshake and multiplier operand choice.
  always_comb begin
    s_tready = 1'b0;
    mul_sel  = MS_X_L1;
    case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_MUL_XL: mul_sel  = MS_X_L1;
      ST_MUL_A:  mul_sel  = MS_P_ODD;
      ST_MUL_B:  mul_sel  = MS_L2_KM1;
      ST_MUL_D:  mul_sel  = MS_L1_ODD;
      default: begin
        s_tready = 1'b0;
        mul_sel  = MS_X_L1;
      end
    endcase
  end

  // Result beat valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            x   <= x_in;
            n   <= deg_in;
            k   <= K_W'(2);
            lm2 <= ONE_Q30;
            lm1 <= x_in;
            dm2 <= '0;
            dm1 <= SLOPE_W'(ONE_Q30);
          end
        end
        ST_MUL_XL: prod <= mul_y;
        ST_ROUND:  p    <= VAL_W'(rnd_sum >>> FRAC_W);
        ST_MUL_A:  acc  <= NUM_W'(mul_y);
        ST_MUL_B:  prod <= mul_y;
        ST_SUB:    num  <= acc - NUM_W'(prod);
        ST_MUL_D: begin
          prod <= mul_y;
          dvd  <= dvd_load;
          neg  <= num[NUM_W-1];
          rem  <= '0;
          dcnt <= '0;
        end
        ST_DIV: begin
          dvd  <= dvd_step;
          rem  <= rem_step;
          dcnt <= dcnt + DIV_CNT_W'(1);
        end
        ST_FIN: begin
          // The extra step only serves q; L and L' stay at degree n.
          if (!last_step) begin
            lm2 <= lm1;
            lm1 <= lk;
            dm2 <= dm1;
            dm1 <= dk;
            k   <= k + K_W'(1);
          end
        end
        ST_OUT: begin
          // lk and lm2 still hold the extra step, so q_sat is valid here.
          if (out_load) begin
            if (n == '0) begin
              // Degree zero is the constant polynomial.
              res_value <= ONE_Q30;
              res_slope <= '0;
              res_q     <= '0;
            end else begin
              res_value <= lm1;
              res_slope <= dm1;
              res_q     <= q_sat;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_tdata = {{(OUT_W - 2*VAL_W - SLOPE_W){1'b0}}, res_q, res_slope, res_value};

endmodule

`default_nettype wire

// ===== tb/tb_legendre_poly_eval.sv =====
// Self-checking testbench for legendre_poly_eval: L_n(x), L'_n(x) and L_{n+1}(x) - L_{n-1}(x).
// Depends on rtl/core/lpe_pkg.sv and rtl/core/legendre_poly_eval.sv; reads no files.
// A directed table runs first, then random beats in four idling phases, checked by a predictor.
`default_nettype none

module tb_legendre_poly_eval;
  timeunit 1ns;
  timeprecision 1ps;

  import lpe_pkg::*;

  localparam int     MAX_DEG          = 63;
  localparam longint UNIT             = 64'sd1 << FRAC_W;
  localparam longint SLOPE_LIM        = UNIT << 11;
  localparam longint Q_HI             = 64'sd2147483647;
  localparam longint Q_LO             = -64'sd2147483648;
  localparam int     RANDOM_PER_PHASE = 250;
  localparam int     NUM_PHASES       = 4;
  // Tail wait, longer than the longest evaluation.
  localparam int     TAIL_CYCLES      = 17 * (MAX_DEG + 1) + 17;
  localparam longint CYCLE_LIMIT      = 64'd6_000_000;

  // Result fields in m_tdata order, value in the lowest bits.
  typedef struct packed {
    logic signed [VAL_W-1:0]   q_value;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [VAL_W-1:0]   value;
  } lpe_result_t;

  typedef struct {
    logic [DEG_W-1:0]        degree;
    logic signed [VAL_W-1:0] point;
    bit                      known;
    lpe_result_t             answer;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  lpe_result_t pending_results[$];
  dir_row_t    dir_rows[$];

  int     src_idle_pct   = 0;
  int     sink_stall_pct = 0;
  int     items_sent     = 0;
  int     results_seen   = 0;
  int     mismatches     = 0;
  int     drains         = 0;
  longint cycles         = 0;

  legendre_poly_eval #(.MAX_DEGREE(MAX_DEG)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: the fixed-point three-term recurrence, all in 64-bit integers.
  // ---------------------------------------------------------------------------
  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Divide by a positive divisor, rounding to nearest with ties away from zero.
  function automatic longint div_nearest(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // L_k from L_{k-1} and L_{k-2}, saturated to [-1, 1].
  function automatic longint legendre_next(longint k, longint x, longint l1, longint l2);
    longint p;
    p = div_nearest(x * l1, UNIT);
    return clamp_to(div_nearest((2 * k - 1) * p - (k - 1) * l2, k), -UNIT, UNIT);
  endfunction

  function automatic lpe_result_t legendre_eval(logic [DEG_W-1:0] degree,
                                                logic signed [VAL_W-1:0] point);
    lpe_result_t r;
    longint      x, lm2, lm1, dm2, dm1, lk, dk, qv;
    int          n;
    n = degree;
    if (n > MAX_DEG) n = MAX_DEG;
    x = clamp_to(longint'(point), -UNIT, UNIT);
    if (n == 0) begin
      lm1 = UNIT;
      dm1 = 0;
      qv  = 0;
    end else begin
      lm2 = UNIT;
      lm1 = x;
      dm2 = 0;
      dm1 = UNIT;
      for (int k = 2; k <= n; k++) begin
        lk  = legendre_next(k, x, lm1, lm2);
        dk  = clamp_to(dm2 + (2 * k - 1) * lm1, -SLOPE_LIM, SLOPE_LIM);
        lm2 = lm1;
        lm1 = lk;
        dm2 = dm1;
        dm1 = dk;
      end
      qv = clamp_to(legendre_next(n + 1, x, lm1, lm2) - lm2, Q_LO, Q_HI);
    end
    r.value   = lm1[VAL_W-1:0];
    r.slope   = dm1[SLOPE_W-1:0];
    r.q_value = qv[VAL_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH %s at result %0d: got %0d, wanted %0d", what, results_seen, got, want);
  endtask

  // Compare each delivered beat with the oldest pending result, then pick the
  // ready level for the next edge.
  always @(posedge clk) begin : result_check
    lpe_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(lpe_result_t)-1:0];
      if (pending_results.size() == 0) begin
        report_mismatch("beat with nothing pending, value", longint'(got.value), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value)
          report_mismatch("value", longint'(got.value), longint'(want.value));
        if (got.slope !== want.slope)
          report_mismatch("slope", longint'(got.slope), longint'(want.slope));
        if (got.q_value !== want.q_value)
          report_mismatch("q_value", longint'(got.q_value), longint'(want.q_value));
      end
      results_seen++;
    end
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycles,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_row(int degree, longint point, bit known,
                         longint v, longint s, longint q);
    dir_row_t row;
    row.degree         = degree[DEG_W-1:0];
    row.point          = point[VAL_W-1:0];
    row.known          = known;
    row.answer.value   = v[VAL_W-1:0];
    row.answer.slope   = s[SLOPE_W-1:0];
    row.answer.q_value = q[VAL_W-1:0];
    dir_rows.push_back(row);
  endtask

  // Offer one beat after a random gap; the result is due once it is taken.
  task automatic send_item(logic [DEG_W-1:0] degree, logic signed [VAL_W-1:0] point,
                           bit known, lpe_result_t given);
    lpe_result_t due;
    due = known ? given : legendre_eval(degree, point);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - DEG_W - VAL_W){1'b0}}, point, degree};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(due);
    items_sent++;
  endtask

  // Hold the input side quiet until every pending result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    drains++;
  endtask

  // Mostly low degrees keep the run short; the top degrees still appear.
  task automatic send_random_item();
    logic [DEG_W-1:0]        degree;
    logic signed [VAL_W-1:0] point;
    longint                  t;
    int                      pick;
    lpe_result_t             none;
    none = '0;
    pick = $urandom_range(99);
    if (pick < 70)      degree = DEG_W'($urandom_range(15));
    else if (pick < 90) degree = DEG_W'($urandom_range(47, 16));
    else                degree = DEG_W'($urandom_range(63, 48));
    pick = $urandom_range(99);
    if (pick < 75) begin
      t     = longint'($urandom_range(32'h8000_0000)) - UNIT;
      point = t[VAL_W-1:0];
    end else if (pick < 85) begin
      case ($urandom_range(5))
        0:       t = UNIT;
        1:       t = -UNIT;
        2:       t = 0;
        3:       t = UNIT + longint'($urandom_range(3));
        4:       t = -UNIT - longint'($urandom_range(3));
        default: t = longint'($urandom_range(7)) - 4;
      endcase
      point = t[VAL_W-1:0];
    end else begin
      // Full 32-bit range, clamped to [-1, 1] inside the block.
      point = $urandom();
    end
    send_item(degree, point, 1'b0, none);
  endtask

  initial begin
    int          src_pct[NUM_PHASES];
    int          sink_pct[NUM_PHASES];
    lpe_result_t known_answer;

    src_pct  = '{0, 59, 0, 10};
    sink_pct = '{0, 0, 59, 10};

    // Rows with the answer typed in are those that follow directly from the
    // definition: degree zero, degree one at zero, and x = 1 where L_n = 1.
    add_row(0,  0,              1, UNIT, 0, 0);
    add_row(0,  32'h7FFF_FFFF,  1, UNIT, 0, 0);
    add_row(0,  -64'sd2147483648, 1, UNIT, 0, 0);
    add_row(1,  0,              1, 0, UNIT, -64'sd1610612736);
    add_row(63, UNIT,           1, UNIT, 2016 * UNIT, 0);
    add_row(1,  UNIT,           0, 0, 0, 0);
    add_row(1,  -UNIT,          0, 0, 0, 0);
    add_row(63, -UNIT,          0, 0, 0, 0);
    add_row(63, 0,              0, 0, 0, 0);
    add_row(2,  32'h7FFF_FFFF,  0, 0, 0, 0);
    add_row(5,  -64'sd2147483648, 0, 0, 0, 0);
    add_row(3,  UNIT + 1,       0, 0, 0, 0);
    add_row(3,  -UNIT - 1,      0, 0, 0, 0);
    add_row(10, 1,              0, 0, 0, 0);
    add_row(10, -1,             0, 0, 0, 0);
    add_row(20, UNIT / 2,       0, 0, 0, 0);
    add_row(40, -UNIT / 2,      0, 0, 0, 0);
    add_row(7,  UNIT - 1,       0, 0, 0, 0);
    add_row(62, 32'h5555_5555,  0, 0, 0, 0);
    add_row(32, -64'sd1431655766, 0, 0, 0, 0);
    add_row(42, 12345678,       0, 0, 0, 0);
    add_row(21, -87654321,      0, 0, 0, 0);
    add_row(48, -UNIT + 1,      0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_pct   = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      if (ph == 0) begin
        foreach (dir_rows[i]) begin
          known_answer = dir_rows[i].answer;
          send_item(dir_rows[i].degree, dir_rows[i].point, dir_rows[i].known, known_answer);
        end
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        send_random_item();
        // Now and then let the block run empty in the middle of a phase.
        if ($urandom_range(49) == 0) drain_results();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered, count", pending_results.size(), 0);

    $display("Covered %0d beats (%0d directed) over four idling phases, %0d results checked,",
             items_sent, dir_rows.size(), results_seen);
    $display("degrees 0 to %0d, points inside and outside [-1, 1], %0d full drains, %0d mismatches.",
             MAX_DEG, drains, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/lpe_pkg.sv
rtl/core/legendre_poly_eval.sv
tb/tb_legendre_poly_eval.sv
